[rtl/core/assert_macros.svh]
// Assertion macros shared by the glob matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an invariant on every clock edge outside reset.
`define WGM_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a same-cycle implication.
`define WGM_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication in the following cycle.
`define WGM_IMPLY_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/wgm_pkg.sv]
// Types and constants of the wildcard glob matcher.
`default_nettype none
package wgm_pkg;

  localparam int MAX_PATTERN = 63;
  localparam int SYMBOL_BITS = 8;
  localparam int NUM_POS     = MAX_PATTERN + 1;
  localparam int LEN_W       = $clog2(NUM_POS);
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CLOSE_LVLS  = (NUM_POS > 1) ? $clog2(NUM_POS) : 1;

  localparam logic [SYMBOL_BITS-1:0] SYM_STAR = SYMBOL_BITS'(42);
  localparam logic [SYMBOL_BITS-1:0] SYM_ANY  = SYMBOL_BITS'(63);

  // Input action codes.
  localparam logic [1:0] ACT_PAT_SYM = 2'd0;
  localparam logic [1:0] ACT_PAT_END = 2'd1;
  localparam logic [1:0] ACT_TGT_SYM = 2'd2;
  localparam logic [1:0] ACT_TGT_END = 2'd3;

  // Commands from front to back.
  localparam logic [2:0] OP_PAT_NEW   = 3'd0;
  localparam logic [2:0] OP_PAT       = 3'd1;
  localparam logic [2:0] OP_CLOSE_NEW = 3'd2;
  localparam logic [2:0] OP_CLOSE     = 3'd3;
  localparam logic [2:0] OP_STEP      = 3'd4;
  localparam logic [2:0] OP_END       = 3'd5;

  typedef struct packed {
    logic [1:0]             action;
    logic [SYMBOL_BITS-1:0] symbol;
  } in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } res_t;

  typedef struct packed {
    logic [2:0]             op;
    logic [SYMBOL_BITS-1:0] sym;
    logic                   is_star;
    logic                   is_any;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/core/wgm_cmdq.sv]
// Two-entry command queue between the front and back of the glob matcher.
`default_nettype none
`include "assert_macros.svh"
module wgm_cmdq import wgm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  output logic valid,
  output cmd_t dout,
  input  logic pop
);

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  cmd_t       e0;
  cmd_t       e1;
  logic       do_push;
  logic       do_pop;
  logic       wr_slot0;

  assign full     = (cnt == 2'd2);
  assign valid    = (cnt != 2'd0);
  assign dout     = e0;
  assign do_push  = push & ~full;
  assign do_pop   = pop & valid;
  assign wr_slot0 = (cnt == 2'd0) || ((cnt == 2'd1) && do_pop);
  assign cnt_next = cnt + 2'(do_push) - 2'(do_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      e0 <= e1;
    end
    if (do_push) begin
      if (wr_slot0) begin
        e0 <= din;
      end else begin
        e1 <= din;
      end
    end
  end

  `WGM_IMPLY(a_cmdq_no_overrun, push && (cnt == 2'd2), pop, "command pushed into full queue")

endmodule
`default_nettype wire

[rtl/core/wgm_front.sv]
// Front end: accept items, track pattern state, turn items into commands.
`default_nettype none
`include "assert_macros.svh"
module wgm_front import wgm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  item,
  input  logic q_full,
  output logic cmd_push,
  output cmd_t cmd
);

  logic closed;
  logic take;
  logic tgt_item;

  assign take     = push & ~q_full;
  assign tgt_item = (item.action == ACT_TGT_SYM) || (item.action == ACT_TGT_END);

  always_comb begin
    cmd.sym     = item.symbol;
    cmd.is_star = (item.symbol == SYM_STAR);
    cmd.is_any  = (item.symbol == SYM_ANY);
    cmd.op      = OP_STEP;
    cmd_push    = 1'b0;
    unique case (item.action)
      ACT_PAT_SYM: begin
        cmd.op   = closed ? OP_PAT_NEW : OP_PAT;
        cmd_push = take;
      end
      ACT_PAT_END: begin
        cmd.op   = closed ? OP_CLOSE_NEW : OP_CLOSE;
        cmd_push = take;
      end
      ACT_TGT_SYM: begin
        cmd.op   = OP_STEP;
        cmd_push = take & closed;
      end
      ACT_TGT_END: begin
        cmd.op   = OP_END;
        cmd_push = take & closed;
      end
      default: begin
        cmd_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      closed <= 1'b1;
    end else if (take) begin
      if (item.action == ACT_PAT_SYM) begin
        closed <= 1'b0;
      end else if (item.action == ACT_PAT_END) begin
        closed <= 1'b1;
      end
    end
  end

  `WGM_IMPLY(a_front_drop_open, take && !closed && tgt_item, !cmd_push, "open target forwarded")

endmodule
`default_nettype wire

[rtl/core/wgm_back.sv]
// Back end: pattern cells, automaton update and result queue.
`default_nettype none
`include "assert_macros.svh"
module wgm_back import wgm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic empty,
  output res_t result,
  input  logic pop
);

  logic [SYMBOL_BITS-1:0] sym_q [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] star_q;
  logic [MAX_PATTERN-1:0] any_q;
  logic [MAX_PATTERN-1:0] inuse;
  logic [LEN_W-1:0]       len;
  logic                   ovf;
  logic [NUM_POS-1:0]     active;

  logic [1:0] ocnt;
  res_t       oq0;
  res_t       oq1;
  logic       out_full;
  logic       out_push;
  logic       out_pop;
  logic       oslot0;
  res_t       res_new;

  logic                   take;
  logic                   room;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [NUM_POS-1:0]     gen;
  logic [NUM_POS-1:0]     seed;
  logic [NUM_POS-1:0]     prop;
  logic [NUM_POS-1:0]     closed_set;
  logic [NUM_POS-1:0]     g;
  logic [NUM_POS-1:0]     p;

  assign out_full = (ocnt == 2'd2);
  assign take     = cmd_valid & ((cmd.op != OP_END) | ~out_full);
  assign cmd_pop  = take;
  assign room     = (len < LEN_W'(MAX_PATTERN));

  // Pattern write port.
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = '0;
    if (take && cmd.op == OP_PAT_NEW) begin
      wr_en = 1'b1;
    end else if (take && cmd.op == OP_PAT && room) begin
      wr_en  = 1'b1;
      wr_idx = len[IDX_W-1:0];
    end
  end

  // One step of every pattern cell in parallel.
  always_comb begin
    gen = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (active[i] && inuse[i]) begin
        if (star_q[i]) begin
          gen[i] = 1'b1;
        end else if (any_q[i] || sym_q[i] == cmd.sym) begin
          gen[i+1] = 1'b1;
        end
      end
    end
  end

  // Star closure as a parallel prefix over the positions.
  always_comb begin
    seed = (cmd.op == OP_STEP) ? gen : NUM_POS'(1);
    prop = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      prop[i+1] = star_q[i] & inuse[i];
    end
    g = seed;
    p = prop;
    for (int lvl = 0; lvl < CLOSE_LVLS; lvl++) begin
      g = g | (p & (g << (1 << lvl)));
      p = p & (p << (1 << lvl));
    end
    closed_set = g;
  end

  assign res_new.matched          = ~ovf & active[len];
  assign res_new.pattern_overflow = ovf;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sym_q[wr_idx]  <= cmd.sym;
      star_q[wr_idx] <= cmd.is_star;
      any_q[wr_idx]  <= cmd.is_any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len    <= '0;
      ovf    <= 1'b0;
      inuse  <= '0;
      active <= NUM_POS'(1);
    end else if (take) begin
      case (cmd.op)
        OP_PAT_NEW: begin
          len   <= LEN_W'(1);
          ovf   <= 1'b0;
          inuse <= MAX_PATTERN'(1);
        end
        OP_PAT: begin
          if (room) begin
            len   <= len + LEN_W'(1);
            inuse <= (inuse << 1) | MAX_PATTERN'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
        OP_CLOSE_NEW: begin
          len    <= '0;
          ovf    <= 1'b0;
          inuse  <= '0;
          active <= NUM_POS'(1);
        end
        default: begin
          // close, target step and end of target all load the closed set
          active <= closed_set;
        end
      endcase
    end
  end

  // Two-entry result queue.
  assign out_push = take & (cmd.op == OP_END);
  assign out_pop  = pop & (ocnt != 2'd0);
  assign oslot0   = (ocnt == 2'd0) || ((ocnt == 2'd1) && out_pop);
  assign empty    = (ocnt == 2'd0);
  assign result   = oq0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else begin
      ocnt <= ocnt + 2'(out_push) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop) begin
      oq0 <= oq1;
    end
    if (out_push) begin
      if (oslot0) begin
        oq0 <= res_new;
      end else begin
        oq1 <= res_new;
      end
    end
  end

  `WGM_CHECK(a_back_fill, $countones(inuse) == int'(len), "fill mask disagrees with length")
  `WGM_IMPLY(a_back_ovf_len, ovf, len == LEN_W'(MAX_PATTERN), "overflow without full store")
  `WGM_IMPLY_NEXT(a_back_end_res, out_push, ocnt != 2'd0, "end of target gave no result")

endmodule
`default_nettype wire

[rtl/core/wildcard_glob_matcher.sv]
// Top level of the wildcard glob matcher.
//
// Usage: the block looks like a queue on both sides. Push an item (action and
// symbol) while full is low; every such edge is one transfer. Pattern symbols
// load the pattern, end of pattern closes it, target symbols step the
// automaton, and end of target produces one result. Pop the result while
// empty is low.
// '*' matches any run of symbols, '?' matches one, others match themselves.
// Target items sent while a pattern is still open are dropped silently.
// A pattern longer than MAX_PATTERN symbols reports pattern_overflow and no
// match on every following target.
// Throughput: one item per cycle while full is low, including target symbols; the
// whole automaton advances across all pattern positions at once.
// Path: with nothing queued ahead, a result passes the command queue register,
// then the result queue register, before it shows on the result ports and
// can be popped.
// Stall: when results are not popped, the result queue fills, the back end
// holds on the next end of target, the command queue fills and full rises.
// Reset: synchronous; the pattern becomes empty and closed, both queues
// drain, so an empty target matches right after reset.
`default_nettype none
module wildcard_glob_matcher import wgm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic empty,
  input  logic pop,
  output res_t result
);

  cmd_t f_cmd;
  logic f_push;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  // Classify items and track whether the pattern is open.
  wgm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .q_full   (full),
    .cmd_push (f_push),
    .cmd      (f_cmd)
  );

  // Decouple the front from a back end stalled on a full result queue.
  wgm_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_cmd),
    .full  (full),
    .valid (q_valid),
    .dout  (q_cmd),
    .pop   (q_pop)
  );

  // Hold the pattern, advance the active set, queue results.
  wgm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .result    (result),
    .pop       (pop)
  );

endmodule
`default_nettype wire

[verif/wildcard_glob_matcher_tb.sv]
// Self-checking testbench for the wildcard glob matcher: directed script plus random glob traffic.
module wildcard_glob_matcher_tb import wgm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SYMBOL_BITS-1:0] LIT_A = SYMBOL_BITS'("a");
  localparam logic [SYMBOL_BITS-1:0] LIT_X = SYMBOL_BITS'("x");
  localparam logic [SYMBOL_BITS-1:0] SYM_LO = '0;
  localparam logic [SYMBOL_BITS-1:0] SYM_HI = '1;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned SCRIPT_ROWS = 25;

  // One row of the directed script: an item repeated reps times, with an
  // optional hand-written verdict for the end-of-target rows.
  typedef struct packed {
    logic [1:0]             act;
    logic [SYMBOL_BITS-1:0] sym;
    logic [6:0]             reps;
    logic                   typed;
    res_t                   want;
  } script_row_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  in_t  item;
  logic empty;
  logic pop;
  res_t result;

  wildcard_glob_matcher u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // Shadow copy of the matcher state.
  logic [SYMBOL_BITS-1:0] glob_chars [MAX_PATTERN];
  int unsigned            glob_len = 0;
  logic [NUM_POS-1:0]     live_pos;
  bit                     glob_closed = 1'b1;
  bit                     glob_ovf = 1'b0;

  res_t        verdicts_due [$];
  script_row_t script [SCRIPT_ROWS];

  logic [SYMBOL_BITS-1:0] pat_q [$];
  logic [SYMBOL_BITS-1:0] tgt_q [$];

  bit          calm = 1'b0;
  int unsigned items_used = 0;
  int unsigned errors = 0;
  int unsigned verdicts_checked = 0;
  int unsigned hits_seen = 0;
  int unsigned ovf_seen = 0;
  int unsigned patterns_closed = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Timeout guard: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("timeout with %0d verdicts outstanding", verdicts_due.size());
    $display("wildcard_glob_matcher_tb NOT OK");
    $finish;
  end

  // Spread activity forward over '*' positions.
  function automatic logic [NUM_POS-1:0] star_close(input logic [NUM_POS-1:0] s);
    for (int i = 0; i < glob_len; i++) begin
      if (s[i] && glob_chars[i] == SYM_STAR) s[i+1] = 1'b1;
    end
    return s;
  endfunction

  function automatic void rearm_live();
    live_pos    = '0;
    live_pos[0] = 1'b1;
    live_pos    = star_close(live_pos);
  endfunction

  // Advance the shadow matcher by one accepted item; return 1 when the item
  // yields a verdict, with the verdict in v.
  function automatic bit glob_advance(input in_t x, output res_t v);
    logic [NUM_POS-1:0] nxt;
    v = '0;
    glob_advance = 1'b0;
    case (x.action)
      ACT_PAT_SYM: begin
        // A symbol after close starts a fresh pattern.
        if (glob_closed) begin
          glob_len    = 0;
          glob_ovf    = 1'b0;
          glob_closed = 1'b0;
        end
        if (glob_len < MAX_PATTERN) begin
          glob_chars[glob_len] = x.symbol;
          glob_len++;
        end else begin
          glob_ovf = 1'b1;
        end
        items_used++;
      end
      ACT_PAT_END: begin
        // Closing an already closed pattern loads the empty one.
        if (glob_closed) begin
          glob_len = 0;
          glob_ovf = 1'b0;
        end
        glob_closed = 1'b1;
        rearm_live();
        patterns_closed++;
        items_used++;
      end
      ACT_TGT_SYM: begin
        if (glob_closed) begin
          nxt = '0;
          for (int i = 0; i < glob_len; i++) begin
            if (live_pos[i]) begin
              if (glob_chars[i] == SYM_STAR) nxt[i] = 1'b1;
              else if (glob_chars[i] == SYM_ANY || glob_chars[i] == x.symbol)
                nxt[i+1] = 1'b1;
            end
          end
          live_pos = star_close(nxt);
          items_used++;
        end
      end
      default: begin
        if (glob_closed) begin
          v.matched          = !glob_ovf && live_pos[glob_len];
          v.pattern_overflow = glob_ovf;
          rearm_live();
          glob_advance = 1'b1;
          items_used++;
        end
      end
    endcase
  endfunction

  function automatic in_t mk(input logic [1:0] act, input logic [SYMBOL_BITS-1:0] sym);
    in_t x;
    x.action = act;
    x.symbol = sym;
    return x;
  endfunction

  // Mostly no gap, some short ones, a few long ones; none in calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SYMBOL_BITS-1:0] pick_pat_sym();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return SYM_STAR;
    if (r < 50) return SYM_ANY;
    if (r < 85) return LIT_A + SYMBOL_BITS'($urandom_range(0, 2));
    return SYMBOL_BITS'($urandom_range(0, 255));
  endfunction

  function automatic logic [SYMBOL_BITS-1:0] pick_tgt_sym();
    if ($urandom_range(0, 99) < 80) return LIT_A + SYMBOL_BITS'($urandom_range(0, 2));
    return SYMBOL_BITS'($urandom_range(0, 255));
  endfunction

  // Build a target that follows the current pattern, then maybe spoil one
  // symbol so near misses show up as well.
  function automatic void derive_target();
    tgt_q.delete();
    foreach (pat_q[i]) begin
      if (pat_q[i] == SYM_STAR) begin
        repeat ($urandom_range(0, 3)) tgt_q.push_back(pick_tgt_sym());
      end else if (pat_q[i] == SYM_ANY) begin
        tgt_q.push_back(SYMBOL_BITS'($urandom_range(0, 255)));
      end else begin
        tgt_q.push_back(pat_q[i]);
      end
    end
    if (tgt_q.size() != 0 && $urandom_range(0, 3) == 0)
      tgt_q[$urandom_range(0, tgt_q.size() - 1)] ^= SYMBOL_BITS'(1) << $urandom_range(0, 7);
  endfunction

  // Offer one item after a random gap and hold it until the transfer; then
  // log the verdict it owes, typed in by hand or from the shadow matcher.
  task automatic send(input in_t x, input bit typed, input res_t want);
    res_t        v;
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    item <= x;
    do @(posedge clk); while (full);
    if (glob_advance(x, v)) verdicts_due.push_back(typed ? want : v);
  endtask

  task automatic send_target();
    foreach (tgt_q[i]) send(mk(ACT_TGT_SYM, tgt_q[i]), 1'b0, '0);
    send(mk(ACT_TGT_END, SYMBOL_BITS'($urandom_range(0, 255))), 1'b0, '0);
  endtask

  // One glob session: load a pattern, close it, run a few targets against it.
  // Some sessions break the rules: stray target items inside the pattern or
  // no close at all, so the next session keeps appending.
  task automatic run_session();
    int unsigned r;
    int unsigned len;
    calm = ($urandom_range(0, 7) == 0);
    r = $urandom_range(0, 99);
    if (r < 4) len = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 7);
    else if (r < 9) len = $urandom_range(40, MAX_PATTERN);
    else len = $urandom_range(0, 8);
    pat_q.delete();
    repeat (len) pat_q.push_back(pick_pat_sym());
    foreach (pat_q[i]) begin
      send(mk(ACT_PAT_SYM, pat_q[i]), 1'b0, '0);
      if ($urandom_range(0, 99) < 3)
        send(mk($urandom_range(0, 1) ? ACT_TGT_SYM : ACT_TGT_END, pick_tgt_sym()), 1'b0, '0);
    end
    if ($urandom_range(0, 99) < 6) begin
      send(mk(ACT_TGT_END, SYM_LO), 1'b0, '0);
      return;
    end
    send(mk(ACT_PAT_END, SYMBOL_BITS'($urandom_range(0, 255))), 1'b0, '0);
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 99) < 60) begin
        derive_target();
      end else begin
        tgt_q.delete();
        repeat ($urandom_range(0, 8)) tgt_q.push_back(pick_tgt_sym());
      end
      send_target();
    end
  endtask

  // Result side: pop with random stalls of mixed length.
  initial begin
    int unsigned hold;
    pop  = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop  <= 1'b1;
        hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Compare every popped verdict against the oldest one due.
  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (verdicts_due.size() == 0) begin
        if (errors < 10)
          $display("unexpected verdict matched=%0b overflow=%0b",
                   result.matched, result.pattern_overflow);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        verdicts_checked++;
        if (result.matched === 1'b1) hits_seen++;
        if (result.pattern_overflow === 1'b1) ovf_seen++;
        if (result.matched !== want.matched ||
            result.pattern_overflow !== want.pattern_overflow) begin
          if (errors < 10)
            $display("verdict %0d: expected matched=%0b overflow=%0b, %s=%0b overflow=%0b",
                     verdicts_checked, want.matched, want.pattern_overflow,
                     "got matched", result.matched, result.pattern_overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned guard;
    rst  = 1'b1;
    push = 1'b0;
    item = '0;
    rearm_live();

    // Directed script. Rows with typed verdicts hold the obvious answers:
    // empty pattern right after reset, overflow, and a full-length pattern.
    script[0]  = '{ACT_TGT_END, SYM_LO,   7'd1,  1'b1, '{1'b1, 1'b0}}; // empty vs empty
    script[1]  = '{ACT_TGT_SYM, SYM_LO,   7'd1,  1'b0, '0};
    script[2]  = '{ACT_TGT_END, SYM_HI,   7'd1,  1'b1, '{1'b0, 1'b0}}; // empty vs one symbol
    script[3]  = '{ACT_PAT_SYM, SYM_STAR, 7'd1,  1'b0, '0};
    script[4]  = '{ACT_PAT_SYM, SYM_ANY,  7'd1,  1'b0, '0};
    script[5]  = '{ACT_PAT_SYM, SYM_HI,   7'd1,  1'b0, '0};
    script[6]  = '{ACT_TGT_SYM, SYM_HI,   7'd1,  1'b0, '0};            // dropped: pattern open
    script[7]  = '{ACT_TGT_END, SYM_LO,   7'd1,  1'b0, '0};            // dropped: pattern open
    script[8]  = '{ACT_PAT_END, SYM_HI,   7'd1,  1'b0, '0};
    script[9]  = '{ACT_TGT_SYM, SYM_LO,   7'd1,  1'b0, '0};
    script[10] = '{ACT_TGT_SYM, SYM_HI,   7'd1,  1'b0, '0};
    script[11] = '{ACT_TGT_END, SYM_LO,   7'd1,  1'b0, '0};
    script[12] = '{ACT_TGT_END, SYM_LO,   7'd1,  1'b0, '0};
    script[13] = '{ACT_PAT_END, SYM_LO,   7'd1,  1'b0, '0};            // close while closed
    script[14] = '{ACT_TGT_END, SYM_LO,   7'd1,  1'b1, '{1'b1, 1'b0}};
    script[15] = '{ACT_PAT_SYM, SYM_ANY,  7'd64, 1'b0, '0};            // one past the store
    script[16] = '{ACT_PAT_END, SYM_LO,   7'd1,  1'b0, '0};
    script[17] = '{ACT_TGT_END, SYM_LO,   7'd1,  1'b1, '{1'b0, 1'b1}};
    script[18] = '{ACT_PAT_END, SYM_LO,   7'd1,  1'b0, '0};            // clears overflow
    script[19] = '{ACT_TGT_END, SYM_LO,   7'd1,  1'b1, '{1'b1, 1'b0}};
    script[20] = '{ACT_PAT_SYM, LIT_X,    7'd63, 1'b0, '0};            // exactly full
    script[21] = '{ACT_PAT_END, SYM_LO,   7'd1,  1'b0, '0};
    script[22] = '{ACT_TGT_SYM, LIT_X,    7'd63, 1'b0, '0};
    script[23] = '{ACT_TGT_END, SYM_LO,   7'd1,  1'b1, '{1'b1, 1'b0}};
    script[24] = '{ACT_TGT_END, SYM_HI,   7'd1,  1'b0, '0};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      repeat (script[i].reps)
        send(mk(script[i].act, script[i].sym), script[i].typed, script[i].want);
    end

    // Random sessions until enough items have had an effect.
    items_used = 0;
    while (items_used < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 10)
        send(mk(2'($urandom_range(0, 3)), SYMBOL_BITS'($urandom_range(0, 255))), 1'b0, '0);
      else
        run_session();
    end
    calm = 1'b0;
    @(negedge clk);
    push <= 1'b0;

    // Drain, then keep the clock running so the pipe can show any stray verdict.
    guard = 0;
    while (verdicts_due.size() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);

    $display("covered %0d patterns closed, %0d verdicts checked (%0d matches, %0d overflows)",
             patterns_closed, verdicts_checked, hits_seen, ovf_seen);
    $display("%0d mismatches or stray verdicts, %0d verdicts still due",
             errors, verdicts_due.size());
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("wildcard_glob_matcher_tb OK");
    end else begin
      $display("wildcard_glob_matcher_tb NOT OK");
    end
    $finish;
  end

endmodule
